// ===== design/teq_pkg.sv =====
package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int TAG_W       = 32;
    localparam int TIME_W      = 32;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic [1:0] RES_ACCEPTED = 2'd0;
    localparam logic [1:0] RES_DROPPED  = 2'd1;
    localparam logic [1:0] RES_RELEASED = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       compare;
        logic       insert;
        logic       release_head;
        logic       emit;
        logic [1:0] emit_kind;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic full;
        logic head_due;
        logic next_due;
        logic out_free;
    } t_stat;

endpackage

// ===== design/timed_event_queue.sv =====
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_kind, i_event_tag, i_release_time, i_current_time
// output    out        o_valid / i_stall  o_result_kind, o_out_tag, o_out_time, o_last_of_run
//
// An insert passes through capture, a parallel compare of all slots, and the shifted write.
// A tick releases the due events from the head, at most sixteen per tick.
// Events leave one per cycle from the head slot unless the output stalls;
// the slot row shifts by one each time.
// Reset is synchronous and active low; it empties the queue and the output register.
// A stalled output holds its transfer and the controller waits before producing the next one.
module timed_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_kind,
    input  logic [teq_pkg::TAG_W-1:0]  i_event_tag,
    input  logic [teq_pkg::TIME_W-1:0] i_release_time,
    input  logic [teq_pkg::TIME_W-1:0] i_current_time,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_result_kind,
    output logic [teq_pkg::TAG_W-1:0]  o_out_tag,
    output logic [teq_pkg::TIME_W-1:0] o_out_time,
    output logic                       o_last_of_run
);

    teq_pkg::t_cmd  w_cmd;
    teq_pkg::t_stat w_stat;

    teq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    teq_dp #(
        .QueueDepth (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_event_tag    (i_event_tag),
        .i_release_time (i_release_time),
        .i_current_time (i_current_time),
        .i_stall        (i_stall),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_out_tag      (o_out_tag),
        .o_out_time     (o_out_time),
        .o_last_of_run  (o_last_of_run)
    );

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.insert |-> !w_stat.full)
        else $error("Insert issued into a full queue.");

    a_release_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.release_head |-> w_stat.head_due)
        else $error("Head released before it was due.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("Result overwrote a pending output transfer.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Input accepted while an item was still in work.");

endmodule

// ===== design/teq_ctrl.sv =====
module teq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  teq_pkg::t_stat i_stat,
    output teq_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_INS_CMP = 2'd1;
    localparam logic [1:0] S_INS_WR  = 2'd2;
    localparam logic [1:0] S_TICK    = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [teq_pkg::CNT_W-1:0] r_cnt;
    logic [teq_pkg::CNT_W-1:0] n_cnt;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.kind == teq_pkg::KIND_TICK) begin
                    n_state = S_TICK;
                end else begin
                    o_cmd.compare = 1'b1;
                    n_state       = S_INS_WR;
                end
            end
            S_INS_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.last      = 1'b1;
                    o_cmd.insert    = !i_stat.full;
                    o_cmd.emit_kind = i_stat.full ? teq_pkg::RES_DROPPED
                                                  : teq_pkg::RES_ACCEPTED;
                    n_state         = S_IDLE;
                end
            end
            S_TICK: begin
                if (!i_stat.head_due) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit         = 1'b1;
                    o_cmd.release_head = 1'b1;
                    o_cmd.emit_kind    = teq_pkg::RES_RELEASED;
                    o_cmd.last         = !(i_stat.next_due &&
                        (r_cnt != teq_pkg::CNT_W'(teq_pkg::MAX_RESULTS - 1)));
                    n_cnt              = r_cnt + 1'b1;
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/teq_dp.sv =====
module teq_dp #(
    parameter int QueueDepth = teq_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_kind,
    input  logic [teq_pkg::TAG_W-1:0]  i_event_tag,
    input  logic [teq_pkg::TIME_W-1:0] i_release_time,
    input  logic [teq_pkg::TIME_W-1:0] i_current_time,
    input  logic                       i_stall,
    input  teq_pkg::t_cmd              i_cmd,
    output teq_pkg::t_stat             o_stat,
    output logic                       o_valid,
    output logic [1:0]                 o_result_kind,
    output logic [teq_pkg::TAG_W-1:0]  o_out_tag,
    output logic [teq_pkg::TIME_W-1:0] o_out_time,
    output logic                       o_last_of_run
);

    localparam int FillW = $clog2(QueueDepth + 1);

    logic [teq_pkg::TIME_W-1:0] r_time [QueueDepth];
    logic [teq_pkg::TAG_W-1:0]  r_tag  [QueueDepth];
    logic [FillW-1:0]           r_fill;
    logic [QueueDepth-1:0]      r_le;
    logic [QueueDepth-1:0]      n_le;
    logic                       r_kind;
    logic [teq_pkg::TAG_W-1:0]  r_in_tag;
    logic [teq_pkg::TIME_W-1:0] r_when;
    logic [teq_pkg::TIME_W-1:0] r_now;
    logic                       r_valid;

    always_comb begin
        for (int i = 0; i < QueueDepth; i++) begin
            n_le[i] = (FillW'(i) < r_fill) && (r_time[i] <= r_when);
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.full     = (r_fill == FillW'(QueueDepth));
    assign o_stat.head_due = (r_fill != '0) && (r_time[0] <= r_now);
    assign o_stat.next_due = (r_fill > FillW'(1)) && (r_time[1] <= r_now);
    assign o_stat.out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_in_tag <= i_event_tag;
            r_when   <= i_release_time;
            r_now    <= i_current_time;
        end
        if (i_cmd.compare) begin
            r_le <= n_le;
        end
        if (i_cmd.insert) begin
            if (!r_le[0]) begin
                r_time[0] <= r_when;
                r_tag[0]  <= r_in_tag;
            end
            for (int i = 1; i < QueueDepth; i++) begin
                if (!r_le[i]) begin
                    if (r_le[i-1]) begin
                        r_time[i] <= r_when;
                        r_tag[i]  <= r_in_tag;
                    end else begin
                        r_time[i] <= r_time[i-1];
                        r_tag[i]  <= r_tag[i-1];
                    end
                end
            end
        end else if (i_cmd.release_head) begin
            for (int i = 0; i < QueueDepth - 1; i++) begin
                r_time[i] <= r_time[i+1];
                r_tag[i]  <= r_tag[i+1];
            end
        end
        if (i_cmd.emit) begin
            o_result_kind <= i_cmd.emit_kind;
            o_last_of_run <= i_cmd.last;
            o_out_tag     <= i_cmd.release_head ? r_tag[0] : r_in_tag;
            o_out_time    <= i_cmd.release_head ? r_time[0] : r_when;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_cmd.release_head) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== dv/tb_timed_event_queue.sv =====
`timescale 1ns / 1ps

module tb_timed_event_queue;

    localparam int IDLE_PCT       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [teq_pkg::TAG_W-1:0]  tag;
        logic [teq_pkg::TIME_W-1:0] due;
        logic                       last;
    } t_event_result;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       i_kind         = teq_pkg::KIND_INSERT;
    logic [teq_pkg::TAG_W-1:0]  i_event_tag    = '0;
    logic [teq_pkg::TIME_W-1:0] i_release_time = '0;
    logic [teq_pkg::TIME_W-1:0] i_current_time = '0;
    logic                       i_stall        = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    logic [1:0]                 o_result_kind;
    logic [teq_pkg::TAG_W-1:0]  o_out_tag;
    logic [teq_pkg::TIME_W-1:0] o_out_time;
    logic                       o_last_of_run;

    logic [teq_pkg::TIME_W-1:0] queued_due[$];
    logic [teq_pkg::TAG_W-1:0]  queued_tag[$];
    t_event_result              pending_results[$];
    logic [teq_pkg::TIME_W-1:0] sim_now      = '0;
    logic                       steady       = 1'b0;
    int unsigned                error_count  = 0;
    int unsigned                quiet_cycles = 0;

    timed_event_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_event_tag    (i_event_tag),
        .i_release_time (i_release_time),
        .i_current_time (i_current_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_out_tag      (o_out_tag),
        .o_out_time     (o_out_time),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void order_event(input logic kind,
                                        input logic [teq_pkg::TAG_W-1:0] tag,
                                        input logic [teq_pkg::TIME_W-1:0] due,
                                        input logic [teq_pkg::TIME_W-1:0] now);
        int            pos;
        int            released;
        int            i;
        t_event_result res;
        if (kind == teq_pkg::KIND_INSERT) begin
            res.tag  = tag;
            res.due  = due;
            res.last = 1'b1;
            if (queued_due.size() >= teq_pkg::QUEUE_DEPTH) begin
                res.kind = teq_pkg::RES_DROPPED;
            end else begin
                pos = 0;
                while (pos < queued_due.size() && (queued_due[pos] <= due)) pos++;
                queued_due.insert(pos, due);
                queued_tag.insert(pos, tag);
                res.kind = teq_pkg::RES_ACCEPTED;
            end
            pending_results.push_back(res);
        end else begin
            released = 0;
            while (released < queued_due.size() && released < teq_pkg::MAX_RESULTS
                   && (queued_due[released] <= now)) released++;
            for (i = 0; i < released; i++) begin
                res.kind = teq_pkg::RES_RELEASED;
                res.tag  = queued_tag[0];
                res.due  = queued_due[0];
                res.last = (i == released - 1);
                pending_results.push_back(res);
                void'(queued_due.pop_front());
                void'(queued_tag.pop_front());
            end
        end
    endfunction

    task automatic send_item(input logic kind, input logic [teq_pkg::TAG_W-1:0] tag,
                             input logic [teq_pkg::TIME_W-1:0] due,
                             input logic [teq_pkg::TIME_W-1:0] now);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_event_tag    <= tag;
        i_release_time <= due;
        i_current_time <= now;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        order_event(kind, tag, due, now);
    endtask

    task automatic send_insert(input logic [teq_pkg::TAG_W-1:0] tag,
                               input logic [teq_pkg::TIME_W-1:0] due);
        send_item(teq_pkg::KIND_INSERT, tag, due, $urandom());
    endtask

    task automatic send_tick(input logic [teq_pkg::TIME_W-1:0] now);
        send_item(teq_pkg::KIND_TICK, $urandom(), $urandom(), now);
    endtask

    function automatic logic [teq_pkg::TIME_W-1:0] pick_due();
        int r;
        r = $urandom_range(99);
        if (r < 80) return sim_now + $urandom_range(24);
        if (r < 92) return $urandom();
        if (r < 96) return '0;
        return '1;
    endfunction

    function automatic logic [teq_pkg::TIME_W-1:0] pick_now();
        int r;
        r = $urandom_range(99);
        sim_now = sim_now + $urandom_range(8);
        if (r < 88) return sim_now;
        if (r < 96) return $urandom();
        return '1;
    endfunction

    task automatic test_empty_tick();
        send_tick('1);
    endtask

    task automatic test_tie_order();
        send_insert('0, 32'd5);
        send_insert('1, 32'd5);
        send_insert($urandom(), '0);
        send_insert($urandom(), '1);
        send_tick(32'd5);
        send_tick('1);
    endtask

    // The depth equals the per-tick release cap, so a full queue drains in one tick.
    task automatic test_full_queue();
        int i;
        for (i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin
            send_insert($urandom(), (i % 4 == 0) ? 32'd50 : ('1 - (i % 3)));
        end
        send_insert($urandom(), '0);
        send_tick('1);
    endtask

    task automatic test_random_traffic();
        int n;
        for (n = 0; n < 70; n++) begin
            if (n == 25) steady <= 1'b1;
            if (n == 50) steady <= 1'b0;
            if ($urandom_range(99) < 60) send_insert($urandom(), pick_due());
            else send_tick(pick_now());
        end
    endtask

    task automatic test_insert_bursts();
        int round;
        int n;
        for (round = 0; round < 2; round++) begin
            for (n = 0; n < 17; n++) send_insert($urandom(), sim_now + $urandom_range(6));
            send_tick(pick_now() + 32'd6);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_event_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d tag %h time %h last %b",
                       o_result_kind, o_out_tag, o_out_time, o_last_of_run);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_kind !== want.kind) begin
                    $error("result_kind: expected %0d, actual %0d", want.kind, o_result_kind);
                    error_count++;
                end
                if (o_out_tag !== want.tag) begin
                    $error("out_tag: expected %h, actual %h", want.tag, o_out_tag);
                    error_count++;
                end
                if (o_out_time !== want.due) begin
                    $error("out_time: expected %h, actual %h", want.due, o_out_time);
                    error_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %b, actual %b", want.last, o_last_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timed_event_queue test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_tick();
        test_tie_order();
        test_full_queue();
        test_random_traffic();
        test_insert_bursts();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("timed_event_queue test passed");
        end else begin
            $display("timed_event_queue test failed");
        end
        $finish;
    end

endmodule
